### rtl/core/smo_pair_alpha_update_assert.svh
// Assertion macros used by the port checker of the SMO pair update block.
`ifndef SMO_PAIR_ALPHA_UPDATE_ASSERT_SVH
`define SMO_PAIR_ALPHA_UPDATE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent. Checking is off during reset.
`define SPAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent. Checking is off during reset.
`define SPAU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent. This check also runs during reset.
`define SPAU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/smo_pau_pkg.sv
// Package with the types, constants and helper functions of the SMO pair update block.
package smo_pau_pkg;

   // Number of fraction bits in the fixed-point format.
   localparam int FRAC_BITS = 16;
   // Number of quotient bits produced by the divider, one per stage.
   localparam int QBITS     = 32;
   // Width of the magnitude of the dividend: a 33-bit gap shifted by the fraction bits.
   localparam int NUM_W     = 33 + FRAC_BITS;
   // Width of the partial remainder. It stays below eta, which is less than 2^34.
   localparam int REM_W     = 34;

   localparam int REQ_DATA_W = 256;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 224;

   // Register addresses on the configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_BOX_COST = 3'd0;
   localparam logic [30:0] BOX_COST_RESET = 31'(64'd1 << FRAC_BITS);

   // Per-request context that travels alongside the divider.
   typedef struct packed {
      logic signed [31:0] a_lo;
      logic signed [31:0] a_hi;
      logic signed [31:0] b_lo;
      logic signed [31:0] b_hi;
      logic [15:0]        lo_idx;
      logic [15:0]        hi_idx;
      logic               same;
      logic               y_lo;
      logic signed [34:0] lo_b;
      logic signed [34:0] hi_b;
      logic               eta_pos;
      logic               q_neg;
      logic               q_ovf;
      logic signed [35:0] alt_na;
   } ctx_type;

   // State of one restoring division stage.
   typedef struct packed {
      logic [REM_W-1:0] eta_mag;
      logic [REM_W-1:0] rem;
      logic [QBITS-1:0] num_lo;
      logic [QBITS-1:0] quo;
   } div_type;

   // Saturate a signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
      logic signed [31:0] r;
      if (x > 37'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -37'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/smo_pair_alpha_update.sv
// Top level of the SMO pair multiplier update: a deep pipeline with a restoring divider.
//
//   Channel | Direction | Handshake               | Contents
//   req     | in        | req_tvalid/req_tready   | one pair: multipliers, labels, kernels, b
//   rsp     | out       | rsp_tvalid/rsp_tready   | new multipliers, changes, echoed fields
//   csr     | in/out    | APB psel/penable        | box_cost register at byte address 0
//
// A request is accepted every cycle while the output register is empty or being taken.
// The divider resolves one quotient bit per stage (32 stages), and seven further stages
// handle bounds, setup, saturation, clipping and the final changes.
// The whole pipeline advances together whenever the output register is empty or being taken.
// Reset clears the valid bits and sets box_cost to 1.0; no clearing pass is needed.
module smo_pair_alpha_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // alpha_low, alpha_high, diag_low, diag_high, pair_kernel, b_low, b_high (32 each),
   // low_index, high_index (16 each)
   input  logic [smo_pau_pkg::REQ_DATA_W-1:0]    req_tdata,
   // label_low, label_high
   input  logic [smo_pau_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // new_alpha_low, new_alpha_high, alpha_low_change, alpha_high_change, b_low_out,
   // b_high_out (32 each), low_index_out, high_index_out (16 each)
   output logic [smo_pau_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [smo_pau_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import smo_pau_pkg::*;

   logic        adv;
   logic [30:0] box_cost_ff;

   logic                  s0_v_ff;
   logic [REQ_DATA_W-1:0] s0_data_ff;
   logic [REQ_USER_W-1:0] s0_user_ff;

   logic               s1_v_ff;
   ctx_type            s1_ctx_ff, s1_ctx_in;
   logic signed [34:0] s1_eta_ff, s1_eta_in;
   logic signed [32:0] s1_gap_ff, s1_gap_in;

   logic    dv_ff  [0:QBITS];
   ctx_type dctx_ff[0:QBITS];
   ctx_type dctx_in0;
   div_type div_ff [0:QBITS];
   div_type div_in0;
   div_type div_in [1:QBITS];

   logic               rq_v_ff;
   ctx_type            rq_ctx_ff;
   logic signed [34:0] rq_na_ff, rq_na_in;

   logic               rc_v_ff;
   ctx_type            rc_ctx_ff;
   logic signed [35:0] rc_na_ff, rc_na_in;

   logic               rd_v_ff;
   ctx_type            rd_ctx_ff;
   logic signed [31:0] rd_nl_ff, rd_nl_in;
   logic signed [31:0] rd_dl_ff, rd_dl_in;

   logic               re_v_ff;
   logic [RSP_DATA_W-1:0] re_data_ff, re_data_in;

   // The pipeline moves whenever the output register can take a new result.
   assign adv        = !re_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = re_v_ff;
   assign rsp_tdata  = re_data_ff;

   // Configuration register and read-back.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_BOX_COST) ? {1'b0, box_cost_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_cost_ff <= BOX_COST_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_ADDR_BOX_COST)) begin
         box_cost_ff <= csr_pwdata[30:0];
      end
   end

   // Stage one: box bounds, curvature and threshold gap.
   always_comb begin
      logic signed [31:0] a_lo, a_hi, d_lo, d_hi, k_pr;
      logic signed [32:0] d, s;
      logic signed [34:0] cost, d_ext, s_ext;
      a_lo = s0_data_ff[31:0];
      a_hi = s0_data_ff[63:32];
      d_lo = s0_data_ff[95:64];
      d_hi = s0_data_ff[127:96];
      k_pr = s0_data_ff[159:128];
      d    = 33'(a_lo) - 33'(a_hi);
      s    = 33'(a_lo) + 33'(a_hi);
      cost  = {4'b0000, box_cost_ff};
      d_ext = 35'(d);
      s_ext = 35'(s);
      s1_ctx_in        = '0;
      s1_ctx_in.a_lo   = a_lo;
      s1_ctx_in.a_hi   = a_hi;
      s1_ctx_in.b_lo   = s0_data_ff[191:160];
      s1_ctx_in.b_hi   = s0_data_ff[223:192];
      s1_ctx_in.lo_idx = s0_data_ff[239:224];
      s1_ctx_in.hi_idx = s0_data_ff[255:240];
      s1_ctx_in.y_lo   = s0_user_ff[0];
      s1_ctx_in.same   = (s0_user_ff[0] == s0_user_ff[1]);
      if (!s1_ctx_in.same) begin
         if (d < 0) begin
            s1_ctx_in.lo_b = '0;
            s1_ctx_in.hi_b = cost + d_ext;
         end else begin
            s1_ctx_in.lo_b = d_ext;
            s1_ctx_in.hi_b = cost;
         end
      end else begin
         if (s_ext < cost) begin
            s1_ctx_in.lo_b = '0;
            s1_ctx_in.hi_b = s_ext;
         end else begin
            s1_ctx_in.lo_b = s_ext - cost;
            s1_ctx_in.hi_b = cost;
         end
      end
      s1_eta_in = 35'(d_lo) + 35'(d_hi) - (35'(k_pr) <<< 1);
      s1_gap_in = 33'($signed(s0_data_ff[223:192])) - 33'($signed(s0_data_ff[191:160]));
   end

   // Stage two: divider setup, overflow test and the endpoint choice for non-positive curvature.
   always_comb begin
      logic [32:0]        gap_mag;
      logic [NUM_W-1:0]   num_mag;
      logic signed [33:0] slope;
      logic signed [35:0] span;
      gap_mag = s1_gap_ff[32] ? 33'(-s1_gap_ff) : 33'(s1_gap_ff);
      num_mag = {gap_mag, {FRAC_BITS{1'b0}}};
      slope   = s1_ctx_ff.y_lo ? 34'(s1_gap_ff) : -34'(s1_gap_ff);
      span    = 36'(s1_ctx_ff.hi_b) - 36'(s1_ctx_ff.lo_b);
      dctx_in0         = s1_ctx_ff;
      dctx_in0.eta_pos = !s1_eta_ff[34] && (s1_eta_ff != '0);
      dctx_in0.q_neg   = s1_gap_ff[32];
      dctx_in0.q_ovf   = ({{(REM_W-(NUM_W-QBITS)){1'b0}}, num_mag[NUM_W-1:QBITS]}
                          >= s1_eta_ff[REM_W-1:0]);
      if (((slope > 0) && (span > 0)) || ((slope < 0) && (span < 0))) begin
         dctx_in0.alt_na = (slope > 0) ? 36'(s1_ctx_ff.hi_b) : 36'(s1_ctx_ff.lo_b);
      end else begin
         dctx_in0.alt_na = 36'(s1_ctx_ff.a_lo);
      end
      div_in0.eta_mag = s1_eta_ff[REM_W-1:0];
      div_in0.rem     = {{(REM_W-(NUM_W-QBITS)){1'b0}}, num_mag[NUM_W-1:QBITS]};
      div_in0.num_lo  = num_mag[QBITS-1:0];
      div_in0.quo     = '0;
   end

   // Divider: each stage shifts in one dividend bit and subtracts eta when it fits.
   always_comb begin
      logic [REM_W:0]   r2;
      logic [REM_W+1:0] diff;
      r2   = '0;
      diff = '0;
      for (int k = 1; k <= QBITS; k++) begin
         r2   = {div_ff[k-1].rem, div_ff[k-1].num_lo[QBITS-1]};
         diff = {1'b0, r2} - {2'b00, div_ff[k-1].eta_mag};
         div_in[k].eta_mag = div_ff[k-1].eta_mag;
         div_in[k].num_lo  = {div_ff[k-1].num_lo[QBITS-2:0], 1'b0};
         if (!diff[REM_W+1]) begin
            div_in[k].rem = diff[REM_W-1:0];
            div_in[k].quo = {div_ff[k-1].quo[QBITS-2:0], 1'b1};
         end else begin
            div_in[k].rem = r2[REM_W-1:0];
            div_in[k].quo = {div_ff[k-1].quo[QBITS-2:0], 1'b0};
         end
      end
   end

   // Quotient saturation and the divided step on the low multiplier.
   always_comb begin
      logic [31:0]        m;
      logic signed [32:0] q;
      ctx_type            c;
      c = dctx_ff[QBITS];
      m = div_ff[QBITS].quo;
      if (c.q_ovf) begin
         q = c.q_neg ? -33'sd2147483648 : 33'sd2147483647;
      end else if (!c.q_neg) begin
         q = m[31] ? 33'sd2147483647 : $signed({1'b0, m});
      end else begin
         q = (m > 32'h8000_0000) ? -33'sd2147483648 : -$signed({1'b0, m});
      end
      rq_na_in = c.y_lo ? (35'(c.a_lo) + 35'(q)) : (35'(c.a_lo) - 35'(q));
   end

   // Clipping to the box, or the endpoint choice when the curvature is not positive.
   always_comb begin
      logic signed [35:0] na;
      na = 36'(rq_na_ff);
      if (!rq_ctx_ff.eta_pos) begin
         rc_na_in = rq_ctx_ff.alt_na;
      end else if (na < 36'(rq_ctx_ff.lo_b)) begin
         rc_na_in = 36'(rq_ctx_ff.lo_b);
      end else if (na > 36'(rq_ctx_ff.hi_b)) begin
         rc_na_in = 36'(rq_ctx_ff.hi_b);
      end else begin
         rc_na_in = na;
      end
   end

   // New low multiplier and its change.
   always_comb begin
      rd_nl_in = sat32(37'(rc_na_ff));
      rd_dl_in = sat32(37'(rd_nl_in) - 37'(rc_ctx_ff.a_lo));
   end

   // Change and new value of the high multiplier, packed into the result.
   always_comb begin
      logic signed [31:0] dh, nh;
      dh = rd_ctx_ff.same ? sat32(-37'(rd_dl_ff)) : rd_dl_ff;
      nh = sat32(37'(rd_ctx_ff.a_hi) + 37'(dh));
      re_data_in = {rd_ctx_ff.hi_idx, rd_ctx_ff.lo_idx, rd_ctx_ff.b_hi, rd_ctx_ff.b_lo,
                    dh, rd_dl_ff, nh, rd_nl_ff};
   end

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         rq_v_ff <= 1'b0;
         rc_v_ff <= 1'b0;
         rd_v_ff <= 1'b0;
         re_v_ff <= 1'b0;
         for (int k = 0; k <= QBITS; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s0_v_ff  <= req_tvalid;
         s1_v_ff  <= s0_v_ff;
         dv_ff[0] <= s1_v_ff;
         for (int k = 1; k <= QBITS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         rq_v_ff <= dv_ff[QBITS];
         rc_v_ff <= rq_v_ff;
         rd_v_ff <= rc_v_ff;
         re_v_ff <= rd_v_ff;
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_data_ff <= req_tdata;
         s0_user_ff <= req_tuser;
         s1_ctx_ff  <= s1_ctx_in;
         s1_eta_ff  <= s1_eta_in;
         s1_gap_ff  <= s1_gap_in;
         dctx_ff[0] <= dctx_in0;
         div_ff[0]  <= div_in0;
         for (int k = 1; k <= QBITS; k++) begin
            dctx_ff[k] <= dctx_ff[k-1];
            div_ff[k]  <= div_in[k];
         end
         rq_ctx_ff  <= dctx_ff[QBITS];
         rq_na_ff   <= rq_na_in;
         rc_ctx_ff  <= rq_ctx_ff;
         rc_na_ff   <= rc_na_in;
         rd_ctx_ff  <= rc_ctx_ff;
         rd_nl_ff   <= rd_nl_in;
         rd_dl_ff   <= rd_dl_in;
         re_data_ff <= re_data_in;
      end
   end

endmodule

### rtl/core/smo_pau_checker.sv
// Port checker for the SMO pair update block and its bind to the top level.
`include "smo_pair_alpha_update_assert.svh"

module smo_pau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [smo_pau_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   // A stalled result stays offered with the same data.
   `SPAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // A stalled result stops the pipeline, so no request is taken.
   `SPAU_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "request taken during output stall")
   // With the output register empty the block always takes a request.
   `SPAU_ASSERT_SAME(a_idle_ready, clock, reset, !rsp_tvalid, req_tready, "block not ready with empty output")
   // Reset empties the pipeline.
   `SPAU_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result offered after reset")
endmodule

bind smo_pair_alpha_update smo_pau_checker u_checker (.*);
